FILE: rtl/two_axis_kalman_tilt_filter_defines.svh
// Assertion macros for the two-axis tilt filter checker
`ifndef TWO_AXIS_KALMAN_TILT_FILTER_DEFINES_SVH
`define TWO_AXIS_KALMAN_TILT_FILTER_DEFINES_SVH

// check that a condition implies a consequence in the next cycle
`define TKF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// check that a condition implies a consequence in the same cycle
`define TKF_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

FILE: rtl/tkf_pkg.sv
// Package: types, constants and a saturating helper for the tilt filter
`timescale 1ns / 1ps
package tkf_pkg;

  localparam int FRAC_BITS = 24;
  localparam int DW        = 32;
  localparam int CW        = 31;
  localparam int TW        = 25;
  localparam int CFG_IDX_W = 3;

  localparam logic [CW-1:0] Q_ANGLE_RST = CW'(((64'd1 << FRAC_BITS) + 64'd500) / 64'd1000);
  localparam logic [CW-1:0] Q_GYRO_RST  =
    CW'(((64'd3 << FRAC_BITS) + 64'd500) / 64'd1000);
  localparam logic [CW-1:0] R_ANGLE_RST = CW'(((64'd3 << FRAC_BITS) + 64'd5) / 64'd10);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_Q_ANGLE_X = 3'd0,
    REG_Q_GYRO_X  = 3'd1,
    REG_R_ANGLE_X = 3'd2,
    REG_Q_ANGLE_Y = 3'd3,
    REG_Q_GYRO_Y  = 3'd4,
    REG_R_ANGLE_Y = 3'd5
  } cfg_reg_t;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2
  } alu_op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RUN,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic start;
    logic signed [DW-1:0] num;
    logic signed [DW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic signed [DW-1:0] quo;
  } div_rsp_t;

  function automatic logic signed [DW-1:0] sat64(input logic signed [65:0] v);
    logic signed [DW-1:0] r;
    if (v > 66'sd2147483647) r = 32'sh7fffffff;
    else if (v < -66'sd2147483648) r = 32'sh80000000;
    else r = v[DW-1:0];
    return r;
  endfunction

endpackage

FILE: rtl/two_axis_kalman_tilt_filter.sv
// Top level: two-axis angle/gyro-bias Kalman filter with a shared ALU and divider
// An update (func 0) runs the X axis then the Y axis through one registered
// add/subtract/multiply unit: 27 ALU steps per axis with one read-after-write
// stall and two serial divisions of 56 iterations each, then a short drain.
// The divider sets most of the time. A zero command (func 1) runs no ALU
// steps. The result sits in an output register; a new item is taken once it
// has been delivered.
`timescale 1ns / 1ps
module two_axis_kalman_tilt_filter (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // gyro_x[31:0], accel_x[63:32], gyro_y[95:64], accel_y[127:96], time_step[152:128]
  input  logic [159:0] s_axis_tdata,
  input  logic         s_axis_tuser,   // func
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // angle_x[31:0], angle_y[63:32]
  output logic [63:0]  m_axis_tdata,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [30:0]  cfg_data
);
  localparam int DW = tkf_pkg::DW;

  // register file slots
  localparam logic [4:0] R_ANG=0, R_BIAS=1, R_AA=2, R_AB=3, R_BA=4, R_BB=5,
    R_GYRO=6, R_ACC=7, R_DT=8, R_QA=9, R_QG=10, R_R=11, R_T0=12, R_T1=13,
    R_S=14, R_K0=15, R_K1=16, R_INNO=17, R_ZERO=18;
  localparam int NR = 19;

  logic signed [DW-1:0] st [2][6];
  logic signed [DW-1:0] rf [NR];
  logic [tkf_pkg::CW-1:0] cq_a [2];
  logic [tkf_pkg::CW-1:0] cq_g [2];
  logic [tkf_pkg::CW-1:0] cr   [2];
  logic signed [DW-1:0] in_g [2];
  logic signed [DW-1:0] in_a [2];
  logic [tkf_pkg::TW-1:0] in_dt;

  tkf_pkg::state_t state, state_next;
  logic        axis;
  logic [5:0]  pc;
  logic        func_q;
  logic [63:0] out_q;
  logic        out_v;

  // micro program: op, src a, src b, dst; dst is written from the registered ALU result
  typedef struct packed {
    tkf_pkg::alu_op_t op;
    logic [4:0] a;
    logic [4:0] b;
    logic [4:0] d;
  } uop_t;
  localparam int NP = 25;
  localparam int DIV_PC = 12;

  function automatic uop_t prog(input logic [5:0] i);
    uop_t u;
    unique case (i)
      6'd0:  u = '{tkf_pkg::OP_SUB, R_GYRO, R_BIAS, R_T0};
      6'd1:  u = '{tkf_pkg::OP_ADD, R_BA, R_AB, R_T1};
      6'd2:  u = '{tkf_pkg::OP_MUL, R_DT, R_T0, R_T0};
      6'd3:  u = '{tkf_pkg::OP_MUL, R_DT, R_T1, R_T1};
      6'd4:  u = '{tkf_pkg::OP_ADD, R_ANG, R_T0, R_ANG};
      6'd5:  u = '{tkf_pkg::OP_MUL, R_QA, R_DT, R_T0};
      6'd6:  u = '{tkf_pkg::OP_MUL, R_DT, R_BB, R_S};
      6'd7:  u = '{tkf_pkg::OP_SUB, R_T0, R_T1, R_T0};
      6'd8:  u = '{tkf_pkg::OP_SUB, R_AB, R_S, R_AB};
      6'd9:  u = '{tkf_pkg::OP_SUB, R_BA, R_S, R_BA};
      6'd10: u = '{tkf_pkg::OP_ADD, R_AA, R_T0, R_AA};
      6'd11: u = '{tkf_pkg::OP_MUL, R_QG, R_DT, R_T1};
      6'd12: u = '{tkf_pkg::OP_ADD, R_AA, R_R, R_S};
      // divisions happen here (k0, k1)
      6'd13: u = '{tkf_pkg::OP_ADD, R_BB, R_T1, R_BB};
      6'd14: u = '{tkf_pkg::OP_SUB, R_ACC, R_ANG, R_INNO};
      6'd15: u = '{tkf_pkg::OP_MUL, R_K0, R_INNO, R_T0};
      6'd16: u = '{tkf_pkg::OP_MUL, R_K1, R_INNO, R_T1};
      6'd17: u = '{tkf_pkg::OP_ADD, R_ANG, R_T0, R_ANG};
      6'd18: u = '{tkf_pkg::OP_ADD, R_BIAS, R_T1, R_BIAS};
      6'd19: u = '{tkf_pkg::OP_MUL, R_K0, R_AA, R_T0};
      6'd20: u = '{tkf_pkg::OP_MUL, R_K0, R_AB, R_T1};
      6'd21: u = '{tkf_pkg::OP_SUB, R_AA, R_T0, R_AA};
      6'd22: u = '{tkf_pkg::OP_SUB, R_AB, R_T1, R_AB};
      6'd23: u = '{tkf_pkg::OP_MUL, R_K1, R_AA, R_T0};
      6'd24: u = '{tkf_pkg::OP_MUL, R_K1, R_AB, R_T1};
      default: u = '{tkf_pkg::OP_ADD, R_ZERO, R_ZERO, R_ZERO};
    endcase
    return u;
  endfunction
  // final two subtractions of cov_ba, cov_bb are in program tail
  function automatic uop_t prog2(input logic [5:0] i);
    uop_t u;
    unique case (i)
      6'd25: u = '{tkf_pkg::OP_SUB, R_BA, R_T0, R_BA};
      6'd26: u = '{tkf_pkg::OP_SUB, R_BB, R_T1, R_BB};
      default: u = prog(i);
    endcase
    return u;
  endfunction
  localparam logic [5:0] LAST = 6'(NP + 1);

  uop_t cur, prv;
  logic wr_en;
  logic signed [DW-1:0] alu_y;
  tkf_pkg::div_req_t dreq;
  tkf_pkg::div_rsp_t drsp;
  logic dsel;  // 0 computing k0, 1 computing k1
  logic data_hazard;

  assign cur = prog2(pc);

  tkf_alu u_alu (.clk(clk), .op(cur.op), .a(rf[cur.a]), .b(rf[cur.b]), .y(alu_y));
  tkf_div u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  // stall when a step reads what the previous step writes
  assign data_hazard = wr_en && (prv.d == cur.a || prv.d == cur.b);

  always_comb begin
    state_next = state;
    unique case (state)
      tkf_pkg::ST_IDLE:
        if (s_axis_tvalid && s_axis_tready)
          state_next = s_axis_tuser ? tkf_pkg::ST_DONE : tkf_pkg::ST_RUN;
      tkf_pkg::ST_RUN:
        if (!data_hazard && pc == 6'(DIV_PC + 1) && !dsel) state_next = tkf_pkg::ST_DIV_START;
        else if (!data_hazard && pc == 6'(NP + 2) && axis) state_next = tkf_pkg::ST_DONE;
      tkf_pkg::ST_DIV_START: state_next = tkf_pkg::ST_DIV_WAIT;
      tkf_pkg::ST_DIV_WAIT:
        if (drsp.done) state_next = dsel ? tkf_pkg::ST_RUN : tkf_pkg::ST_DIV_START;
      tkf_pkg::ST_DONE: if (!out_v) state_next = tkf_pkg::ST_IDLE;
      default: state_next = tkf_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = (state == tkf_pkg::ST_IDLE) && !out_v;
    dreq.start = (state == tkf_pkg::ST_DIV_START);
    dreq.num   = dsel ? rf[R_BA] : rf[R_AA];
    dreq.den   = rf[R_S];
  end

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tkf_pkg::ST_IDLE;
      out_v <= 1'b0;
      wr_en <= 1'b0;
      pc    <= '0;
      axis  <= 1'b0;
      dsel  <= 1'b0;
      cq_a[0] <= tkf_pkg::Q_ANGLE_RST; cq_a[1] <= tkf_pkg::Q_ANGLE_RST;
      cq_g[0] <= tkf_pkg::Q_GYRO_RST;  cq_g[1] <= tkf_pkg::Q_GYRO_RST;
      cr[0]   <= tkf_pkg::R_ANGLE_RST; cr[1]   <= tkf_pkg::R_ANGLE_RST;
      for (int i = 0; i < 2; i++)
        for (int j = 0; j < 6; j++) st[i][j] <= '0;
    end else begin
      state <= state_next;
      if (m_axis_tvalid && m_axis_tready) out_v <= 1'b0;
      if (cfg_valid) begin
        unique case (cfg_index)
          tkf_pkg::REG_Q_ANGLE_X: cq_a[0] <= cfg_data;
          tkf_pkg::REG_Q_GYRO_X:  cq_g[0] <= cfg_data;
          tkf_pkg::REG_R_ANGLE_X: cr[0]   <= cfg_data;
          tkf_pkg::REG_Q_ANGLE_Y: cq_a[1] <= cfg_data;
          tkf_pkg::REG_Q_GYRO_Y:  cq_g[1] <= cfg_data;
          tkf_pkg::REG_R_ANGLE_Y: cr[1]   <= cfg_data;
          default: ;
        endcase
      end
      wr_en <= 1'b0;
      prv   <= cur;
      if (wr_en) rf[prv.d] <= alu_y;
      rf[R_ZERO] <= '0;
      unique case (state)
        tkf_pkg::ST_IDLE:
          if (s_axis_tvalid && s_axis_tready) begin
            func_q <= s_axis_tuser;
            in_g[0] <= s_axis_tdata[31:0];   in_a[0] <= s_axis_tdata[63:32];
            in_g[1] <= s_axis_tdata[95:64];  in_a[1] <= s_axis_tdata[127:96];
            in_dt   <= s_axis_tdata[152:128];
            pc <= '0; axis <= 1'b0; dsel <= 1'b0;
            rf[R_ANG] <= st[0][0]; rf[R_BIAS] <= st[0][1]; rf[R_AA] <= st[0][2];
            rf[R_AB]  <= st[0][3]; rf[R_BA]   <= st[0][4]; rf[R_BB] <= st[0][5];
            rf[R_GYRO] <= s_axis_tdata[31:0]; rf[R_ACC] <= s_axis_tdata[63:32];
            rf[R_DT] <= DW'(s_axis_tdata[152:128]);
            rf[R_QA] <= DW'(cq_a[0]); rf[R_QG] <= DW'(cq_g[0]); rf[R_R] <= DW'(cr[0]);
          end
        tkf_pkg::ST_RUN:
          if (!data_hazard) begin
            if (pc == 6'(DIV_PC + 1) && !dsel) begin
              // hold pc: S is written at the end of this cycle, divisions follow
            end else if (pc == LAST) begin
              wr_en <= 1'b1;
              pc    <= 6'(NP + 2);
            end else if (pc == 6'(NP + 2)) begin
              // last write of the axis lands at the end of this cycle
              if (!axis) pc <= 6'(NP + 3);
            end else if (pc == 6'(NP + 3)) begin
              // save X, load Y
              st[0][0] <= rf[R_ANG]; st[0][1] <= rf[R_BIAS]; st[0][2] <= rf[R_AA];
              st[0][3] <= rf[R_AB];  st[0][4] <= rf[R_BA];   st[0][5] <= rf[R_BB];
              rf[R_ANG] <= st[1][0]; rf[R_BIAS] <= st[1][1]; rf[R_AA] <= st[1][2];
              rf[R_AB]  <= st[1][3]; rf[R_BA]   <= st[1][4]; rf[R_BB] <= st[1][5];
              rf[R_GYRO] <= in_g[1]; rf[R_ACC] <= in_a[1]; rf[R_DT] <= DW'(in_dt);
              rf[R_QA] <= DW'(cq_a[1]); rf[R_QG] <= DW'(cq_g[1]); rf[R_R] <= DW'(cr[1]);
              axis <= 1'b1;
              pc <= '0; dsel <= 1'b0;
            end else begin
              wr_en <= 1'b1;
              pc    <= pc + 1'b1;
            end
          end
        tkf_pkg::ST_DIV_WAIT:
          if (drsp.done) begin
            if (!dsel) begin
              rf[R_K0] <= (rf[R_S] > 0) ? drsp.quo : '0;
              dsel <= 1'b1;
            end else begin
              rf[R_K1] <= (rf[R_S] > 0) ? drsp.quo : '0;
              pc <= 6'(DIV_PC + 1);
            end
          end
        tkf_pkg::ST_DONE:
          if (!out_v) begin
            if (func_q) begin
              st[0][0] <= '0; st[1][0] <= '0;
              out_q <= '0;
            end else begin
              st[1][0] <= rf[R_ANG]; st[1][1] <= rf[R_BIAS]; st[1][2] <= rf[R_AA];
              st[1][3] <= rf[R_AB];  st[1][4] <= rf[R_BA];   st[1][5] <= rf[R_BB];
              out_q <= {rf[R_ANG], st[0][0]};
            end
            out_v <= 1'b1;
          end
        default: ;
      endcase
    end
  end

  assign m_axis_tvalid = out_v;
  assign m_axis_tdata  = out_q;
endmodule

FILE: rtl/tkf_alu.sv
// Shared saturating add, subtract and fixed point multiply unit
`timescale 1ns / 1ps
module tkf_alu (
  input  logic                                clk,
  input  tkf_pkg::alu_op_t                    op,
  input  logic signed [tkf_pkg::DW-1:0]       a,
  input  logic signed [tkf_pkg::DW-1:0]       b,
  output logic signed [tkf_pkg::DW-1:0]       y
);
  logic signed [65:0] wide;
  logic signed [63:0] prod;

  always_comb begin
    prod = 64'(a) * 64'(b);
    unique case (op)
      tkf_pkg::OP_ADD: wide = 66'(a) + 66'(b);
      tkf_pkg::OP_SUB: wide = 66'(a) - 66'(b);
      tkf_pkg::OP_MUL: wide = 66'(prod >>> tkf_pkg::FRAC_BITS);
      default:         wide = '0;
    endcase
  end

  // result registered; the sequencer writes it back into its register file
  always_ff @(posedge clk) begin
    y <= tkf_pkg::sat64(wide);
  end
endmodule

FILE: rtl/tkf_div.sv
// Restoring serial divider: (num << FRAC_BITS) / den, toward zero, saturated
`timescale 1ns / 1ps
module tkf_div (
  input  logic                clk,
  input  logic                rst,
  input  tkf_pkg::div_req_t   req,
  output tkf_pkg::div_rsp_t   rsp
);
  localparam int NW = tkf_pkg::DW + tkf_pkg::FRAC_BITS;
  localparam int KW = $clog2(NW + 1);

  logic [NW-1:0]             quo;
  logic [tkf_pkg::DW:0]      rem;
  logic [tkf_pkg::DW-1:0]    dv;
  logic                      neg;
  logic [KW-1:0]             cnt;
  logic                      busy;
  logic                      done;
  logic [tkf_pkg::DW:0]      trial;
  logic [tkf_pkg::DW:0]      shl;
  logic signed [65:0]        sq;

  always_comb begin
    shl   = {rem[tkf_pkg::DW-1:0], quo[NW-1]};
    trial = shl - {1'b0, dv};
    sq    = neg ? -66'(signed'({1'b0, quo})) : 66'(signed'({1'b0, quo}));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= KW'(NW);
        neg  <= req.num[tkf_pkg::DW-1];
        quo  <= {(req.num[tkf_pkg::DW-1] ? tkf_pkg::DW'(-req.num) : tkf_pkg::DW'(req.num)),
                 {tkf_pkg::FRAC_BITS{1'b0}}};
        rem  <= '0;
        dv   <= req.den;
      end else if (busy) begin
        if (trial[tkf_pkg::DW]) begin
          rem <= shl;
          quo <= {quo[NW-2:0], 1'b0};
        end else begin
          rem <= trial;
          quo <= {quo[NW-2:0], 1'b1};
        end
        cnt <= cnt - 1'b1;
        if (cnt == KW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.busy = busy;
  assign rsp.done = done;
  assign rsp.quo  = tkf_pkg::sat64(sq);
endmodule

FILE: rtl/tkf_checker.sv
// Port-level checker for the tilt filter, bound to the top level
`timescale 1ns / 1ps
`include "two_axis_kalman_tilt_filter_defines.svh"
module tkf_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [63:0]  m_axis_tdata
);
  `TKF_ASSERT_NOW(a_no_take_while_full, clk, rst, m_axis_tvalid, !s_axis_tready, "input taken while result pending")
  `TKF_ASSERT_NEXT(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result dropped while stalled")
  `TKF_ASSERT_NEXT(a_busy_after_take, clk, rst, s_axis_tvalid && s_axis_tready, !s_axis_tready, "ready straight after a transaction")
endmodule

bind two_axis_kalman_tilt_filter tkf_checker u_tkf_checker (
  .clk(clk), .rst(rst), .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
);
